// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl files of the frame finder
// expects signals named clk and arst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CFFF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define CFFF_ASSERT_NEVER(label, cond, msg) \
	`CFFF_ASSERT(label, !(cond), msg)

`endif

// ----- hw/rtl/cfff_pkg.sv -----
// constants, types and codes of the crc checked frame finder
// no dependencies; used by cfff_crc_unit, cfff_seq and crc_checked_frame_finder
`timescale 1ns / 1ps

package cfff_pkg;

	localparam int BUFFER_BYTES   = 4096;
	localparam int FRAME_OVERHEAD = 9;
	localparam int HDR_BYTES      = 4;
	localparam int FCS_BYTES      = 4;

	localparam int ADDR_W    = $clog2(BUFFER_BYTES);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int LEN_W     = 16;
	localparam int CRC_CNT_W = LEN_W + 1;
	localparam int BOUND_W   = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 2;
	localparam int OFFSET_W  = 12;

	localparam logic [7:0]  HEAD_BYTE = 8'hEF;
	localparam logic [7:0]  TAIL_BYTE = 8'hFE;
	localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
	localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

	typedef enum logic [0:0] {
		REG_WANTED_COMMAND = 1'b0,
		REG_MATCH_ANY      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] wanted_command;
		logic       match_any_command;
	} cfg_t;

	typedef enum logic [1:0] {
		CRC_HOLD  = 2'd0,
		CRC_START = 2'd1,
		CRC_FEED  = 2'd2,
		CRC_SHIFT = 2'd3
	} crc_op_t;

	typedef struct packed {
		crc_op_t    op;
		logic [7:0] data;
	} crc_ctl_t;

	typedef struct packed {
		logic                frame_found;
		logic [OFFSET_W-1:0] frame_offset;
		logic                overflowed;
	} result_t;

endpackage

// ----- hw/rtl/cfff_in_if.sv -----
// input channel: one buffer byte per word with its last-byte mark
// depends on nothing
`timescale 1ns / 1ps

interface cfff_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

// ----- hw/rtl/cfff_out_if.sv -----
// result channel: search outcome for one buffer per word
// depends on nothing
`timescale 1ns / 1ps

interface cfff_out_if;
	logic        valid;
	logic        ready;
	logic        frame_found;
	logic [11:0] frame_offset;
	logic        overflowed;

	modport source (output valid, output frame_found, output frame_offset,
		output overflowed, input ready);
	modport sink (input valid, input frame_found, input frame_offset,
		input overflowed, output ready);
endinterface

// ----- hw/rtl/cfff_crc_unit.sv -----
// shared crc-32/mpeg-2 unit: one byte per cycle, plus a byte shift for the fcs compare
// depends on cfff_pkg
`timescale 1ns / 1ps

module cfff_crc_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  cfff_pkg::crc_ctl_t ctl,
	output logic [7:0]       top_byte
);

	logic [31:0] crc_q;
	logic [31:0] crc_next;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {b, 24'h0};
		for (int k = 0; k < 8; k++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ cfff_pkg::CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

	always_comb begin
		unique case (ctl.op)
			cfff_pkg::CRC_HOLD:  crc_next = crc_q;
			cfff_pkg::CRC_START: crc_next = cfff_pkg::CRC_INIT;
			cfff_pkg::CRC_FEED:  crc_next = crc_byte(crc_q, ctl.data);
			cfff_pkg::CRC_SHIFT: crc_next = {crc_q[23:0], 8'h00};
			default:             crc_next = crc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= cfff_pkg::CRC_INIT;
		end else begin
			crc_q <= crc_next;
		end
	end

	assign top_byte = crc_q[31:24];

endmodule

// ----- hw/rtl/cfff_seq.sv -----
// byte store and search sequencer: loads the buffer, then walks start offsets
// depends on cfff_pkg, cfff_in_if, assert_macros.svh; drives cfff_crc_unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfff_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	cfff_in_if.sink               in,
	input  cfff_pkg::cfg_t        cfg,
	output cfff_pkg::crc_ctl_t    crc_ctl,
	input  logic [7:0]            crc_top,
	output logic                  res_valid,
	output cfff_pkg::result_t     res,
	input  logic                  slot_free
);

	localparam int ADDR_W    = cfff_pkg::ADDR_W;
	localparam int CNT_W     = cfff_pkg::CNT_W;
	localparam int LEN_W     = cfff_pkg::LEN_W;
	localparam int CRC_CNT_W = cfff_pkg::CRC_CNT_W;
	localparam int BOUND_W   = cfff_pkg::BOUND_W;

	typedef enum logic [15:0] {
		S_LOAD    = 16'h0001,
		S_HEAD_RD = 16'h0002,
		S_HEAD_CK = 16'h0004,
		S_CMD_RD  = 16'h0008,
		S_CMD_CK  = 16'h0010,
		S_LENH_RD = 16'h0020,
		S_LENH_CK = 16'h0040,
		S_LENL_RD = 16'h0080,
		S_LENL_CK = 16'h0100,
		S_TAIL_RD = 16'h0200,
		S_TAIL_CK = 16'h0400,
		S_CRC_RD  = 16'h0800,
		S_CRC_CK  = 16'h1000,
		S_FCS_RD  = 16'h2000,
		S_FCS_CK  = 16'h4000,
		S_DONE    = 16'h8000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     len_q;
	logic [ADDR_W-1:0]    start_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [LEN_W-1:0]     dlen_q;
	logic [CRC_CNT_W-1:0] crc_cnt_q;
	logic [1:0]           fcs_cnt_q;
	logic                 found_q;
	logic [7:0]           rdata_q;
	logic [7:0]           mem [cfff_pkg::BUFFER_BYTES];

	logic                 accept;
	logic                 full;
	logic [CNT_W-1:0]     cnt_next;
	logic                 ovf_next;
	logic [LEN_W-1:0]     dlen_w;
	logic [BOUND_W-1:0]   bound;
	logic [BOUND_W-1:0]   tail_pos;
	logic [BOUND_W-1:0]   next_start;
	logic                 more_starts;
	logic                 fail;
	logic                 rd_state;

	assign in.ready = (state_q == S_LOAD);
	assign accept   = in.valid && in.ready;
	assign full     = (cnt_q == CNT_W'(cfff_pkg::BUFFER_BYTES));
	assign cnt_next = full ? cnt_q : cnt_q + CNT_W'(1);
	assign ovf_next = ovf_q || full;

	assign dlen_w     = {dlen_q[LEN_W-1:8], rdata_q};
	assign bound      = BOUND_W'(dlen_w) + BOUND_W'(start_q) + BOUND_W'(cfff_pkg::FRAME_OVERHEAD);
	assign tail_pos   = BOUND_W'(dlen_w) + BOUND_W'(start_q) + BOUND_W'(cfff_pkg::HDR_BYTES);
	assign next_start = BOUND_W'(start_q) + BOUND_W'(1);
	assign more_starts = (BOUND_W'(len_q) >=
		next_start + BOUND_W'(cfff_pkg::FRAME_OVERHEAD));

	// a check state rejects the current start offset
	always_comb begin
		fail = 1'b0;
		unique case (state_q)
			S_HEAD_CK: fail = (rdata_q != cfff_pkg::HEAD_BYTE);
			S_CMD_CK:  fail = !cfg.match_any_command && (rdata_q != cfg.wanted_command);
			S_LENL_CK: fail = (bound > BOUND_W'(len_q));
			S_TAIL_CK: fail = (rdata_q != cfff_pkg::TAIL_BYTE);
			S_FCS_CK:  fail = (rdata_q != crc_top);
			default:   fail = 1'b0;
		endcase
	end

	always_comb begin
		crc_ctl.op   = cfff_pkg::CRC_HOLD;
		crc_ctl.data = rdata_q;
		unique case (state_q)
			S_TAIL_CK: crc_ctl.op = fail ? cfff_pkg::CRC_HOLD : cfff_pkg::CRC_START;
			S_CRC_CK:  crc_ctl.op = cfff_pkg::CRC_FEED;
			S_FCS_CK:  crc_ctl.op = fail ? cfff_pkg::CRC_HOLD : cfff_pkg::CRC_SHIFT;
			default:   crc_ctl.op = cfff_pkg::CRC_HOLD;
		endcase
	end

	assign rd_state = (state_q == S_HEAD_RD) || (state_q == S_CMD_RD) ||
		(state_q == S_LENH_RD) || (state_q == S_LENL_RD) || (state_q == S_TAIL_RD) ||
		(state_q == S_CRC_RD) || (state_q == S_FCS_RD);

	// byte store, one write port while loading, one registered read port
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[cnt_q[ADDR_W-1:0]] <= in.data_byte;
		end
		rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (fail) begin
			if (more_starts) begin
				start_q <= next_start[ADDR_W-1:0];
				ptr_q   <= next_start[ADDR_W-1:0];
				state_q <= S_HEAD_RD;
			end else begin
				found_q <= 1'b0;
				state_q <= S_DONE;
			end
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_next;
						ovf_q <= ovf_next;
						if (in.is_last) begin
							len_q   <= cnt_next;
							start_q <= '0;
							ptr_q   <= '0;
							found_q <= 1'b0;
							state_q <= (cnt_next < CNT_W'(cfff_pkg::FRAME_OVERHEAD)) ?
								S_DONE : S_HEAD_RD;
						end
					end
				end
				S_HEAD_RD: state_q <= S_HEAD_CK;
				S_HEAD_CK: begin
					ptr_q   <= ptr_q + ADDR_W'(1);
					state_q <= S_CMD_RD;
				end
				S_CMD_RD: state_q <= S_CMD_CK;
				S_CMD_CK: begin
					ptr_q   <= ptr_q + ADDR_W'(1);
					state_q <= S_LENH_RD;
				end
				S_LENH_RD: state_q <= S_LENH_CK;
				S_LENH_CK: begin
					dlen_q[LEN_W-1:8] <= rdata_q;
					ptr_q   <= ptr_q + ADDR_W'(1);
					state_q <= S_LENL_RD;
				end
				S_LENL_RD: state_q <= S_LENL_CK;
				S_LENL_CK: begin
					dlen_q  <= dlen_w;
					ptr_q   <= tail_pos[ADDR_W-1:0];
					state_q <= S_TAIL_RD;
				end
				S_TAIL_RD: state_q <= S_TAIL_CK;
				S_TAIL_CK: begin
					ptr_q     <= start_q;
					crc_cnt_q <= CRC_CNT_W'(dlen_q) + CRC_CNT_W'(cfff_pkg::HDR_BYTES + 1);
					state_q   <= S_CRC_RD;
				end
				S_CRC_RD: state_q <= S_CRC_CK;
				S_CRC_CK: begin
					ptr_q     <= ptr_q + ADDR_W'(1);
					crc_cnt_q <= crc_cnt_q - CRC_CNT_W'(1);
					fcs_cnt_q <= '0;
					state_q   <= (crc_cnt_q == CRC_CNT_W'(1)) ? S_FCS_RD : S_CRC_RD;
				end
				S_FCS_RD: state_q <= S_FCS_CK;
				S_FCS_CK: begin
					// fcs byte matched the top crc byte; the unit shifts the next one up
					ptr_q     <= ptr_q + ADDR_W'(1);
					fcs_cnt_q <= fcs_cnt_q + 2'd1;
					if (fcs_cnt_q == 2'(cfff_pkg::FCS_BYTES - 1)) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_FCS_RD;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign res_valid        = (state_q == S_DONE);
	assign res.frame_found  = found_q;
	assign res.frame_offset = found_q ? cfff_pkg::OFFSET_W'(start_q) : '0;
	assign res.overflowed   = ovf_q;

	`CFFF_ASSERT(a_read_in_buffer, rd_state |-> (CNT_W'(ptr_q) < len_q),
		"read address beyond the loaded buffer")
	`CFFF_ASSERT(a_found_fits, (res_valid && found_q) |->
		(BOUND_W'(start_q) + BOUND_W'(cfff_pkg::FRAME_OVERHEAD) <= BOUND_W'(len_q)),
		"reported frame start leaves no room for a frame")
	`CFFF_ASSERT_NEVER(a_count_bound, cnt_q > CNT_W'(cfff_pkg::BUFFER_BYTES),
		"byte count beyond buffer capacity")

endmodule

// ----- hw/rtl/crc_checked_frame_finder.sv -----
// Loading: one byte word per cycle; input ready only while loading, not in search or done.
// Search: per start offset each byte read from the store takes a read and a check state:
//   head, command and both length bytes, then the tail, L+5 crc bytes, up to 4 fcs bytes.
// Result: held until the output register is free, then registered there; loading resumes then.
// Reset returns control to loading and configuration to match-any; the byte store is not cleared.
`timescale 1ns / 1ps

module crc_checked_frame_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	cfff_in_if.sink     in,
	cfff_out_if.source  out
);

	cfff_pkg::cfg_t     cfg_q;
	cfff_pkg::crc_ctl_t crc_ctl;
	cfff_pkg::result_t  res;
	cfff_pkg::result_t  out_q;
	logic               res_valid;
	logic               out_valid_q;
	logic               slot_free;
	logic [7:0]         crc_top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_command    <= 8'h00;
			cfg_q.match_any_command <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfff_pkg::cfg_reg_t'(cfg_index))
				cfff_pkg::REG_WANTED_COMMAND: cfg_q.wanted_command    <= cfg_data;
				cfff_pkg::REG_MATCH_ANY:      cfg_q.match_any_command <= cfg_data[0];
				default:                      cfg_q                   <= cfg_q;
			endcase
		end
	end

	cfff_crc_unit u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (crc_ctl),
		.top_byte (crc_top)
	);

	cfff_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cfg       (cfg_q),
		.crc_ctl   (crc_ctl),
		.crc_top   (crc_top),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free)
	);

	// output register parts the search from the result consumer
	assign slot_free = !out_valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res_valid) begin
			out_q <= res;
		end
	end

	assign out.valid        = out_valid_q;
	assign out.frame_found  = out_q.frame_found;
	assign out.frame_offset = out_q.frame_offset;
	assign out.overflowed   = out_q.overflowed;

endmodule

// ----- sim/tb_top.sv -----
// testbench for crc_checked_frame_finder: loads byte buffers, predicts the frame search
// result in its own model and compares every result word field by field
// depends on cfff_pkg, cfff_in_if, cfff_out_if and the block itself
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_word_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_CRC,
		FLAW_TAIL,
		FLAW_TRUNC,
		FLAW_CMD
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	cfff_in_if byte_in();
	cfff_out_if verdict_out();

	crc_checked_frame_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in(byte_in),
		.out(verdict_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	byte_word_t word_q[$];
	cfff_pkg::result_t verdict_q[$];
	cfff_pkg::result_t due_r;
	int errors = 0;
	int send_idle_pct;
	int recv_idle_pct;
	logic hold_arm;
	int hold_left;

	// predictor state
	logic [7:0] store_mem [cfff_pkg::BUFFER_BYTES];
	int unsigned fill_cnt = 0;
	logic overflow_seen = 1'b0;
	logic [7:0] want_cmd = 8'h00;
	logic any_cmd = 1'b1;

	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
		logic [31:0] r;
		r = c ^ {d, 24'h0};
		repeat (8) r = r[31] ? ((r << 1) ^ cfff_pkg::CRC_POLY) : (r << 1);
		return r;
	endfunction

	function automatic bit frame_ok(int s, int len);
		int dlen;
		int i;
		logic [31:0] c;
		logic [31:0] fcs;
		if (store_mem[s] != cfff_pkg::HEAD_BYTE)
			return 1'b0;
		if (!any_cmd && store_mem[s + 1] != want_cmd)
			return 1'b0;
		dlen = {store_mem[s + 2], store_mem[s + 3]};
		if (s + dlen + cfff_pkg::FRAME_OVERHEAD > len)
			return 1'b0;
		if (store_mem[s + 4 + dlen] != cfff_pkg::TAIL_BYTE)
			return 1'b0;
		c = cfff_pkg::CRC_INIT;
		for (i = 0; i < dlen + 5; i++)
			c = crc_step(c, store_mem[s + i]);
		fcs = {store_mem[s + dlen + 5], store_mem[s + dlen + 6],
			store_mem[s + dlen + 7], store_mem[s + dlen + 8]};
		return fcs == c;
	endfunction

	function automatic cfff_pkg::result_t search_buffer();
		cfff_pkg::result_t r;
		int s;
		r = '0;
		r.overflowed = overflow_seen;
		for (s = 0; s + cfff_pkg::FRAME_OVERHEAD <= int'(fill_cnt); s++) begin
			if (frame_ok(s, fill_cnt)) begin
				r.frame_found = 1'b1;
				r.frame_offset = 12'(s);
				break;
			end
		end
		return r;
	endfunction

	function automatic void take_byte(logic [7:0] d, logic last);
		if (fill_cnt < cfff_pkg::BUFFER_BYTES) begin
			store_mem[fill_cnt] = d;
			fill_cnt++;
		end else begin
			overflow_seen = 1'b1;
		end
		if (last) begin
			verdict_q.push_back(search_buffer());
			fill_cnt = 0;
			overflow_seen = 1'b0;
		end
	endfunction

	function automatic void append_noise(ref logic [7:0] b[$], input int n, input int head_pct);
		repeat (n) b.push_back(($urandom_range(99) < head_pct) ? cfff_pkg::HEAD_BYTE :
			8'($urandom));
	endfunction

	function automatic void append_frame(ref logic [7:0] b[$], input logic [7:0] cmd,
		input int dlen, input flaw_t flaw);
		int first;
		int i;
		logic [31:0] c;
		first = b.size();
		b.push_back(cfff_pkg::HEAD_BYTE);
		b.push_back((flaw == FLAW_CMD) ? cmd ^ 8'($urandom_range(1, 255)) : cmd);
		b.push_back(8'(dlen >> 8));
		b.push_back(8'(dlen));
		repeat (dlen) b.push_back(8'($urandom));
		b.push_back((flaw == FLAW_TAIL) ? cfff_pkg::TAIL_BYTE ^ 8'($urandom_range(1, 255)) :
			cfff_pkg::TAIL_BYTE);
		c = cfff_pkg::CRC_INIT;
		for (i = 0; i < dlen + 5; i++)
			c = crc_step(c, b[first + i]);
		if (flaw == FLAW_CRC)
			c ^= 32'h1 << $urandom_range(0, 31);
		b.push_back(c[31:24]);
		b.push_back(c[23:16]);
		b.push_back(c[15:8]);
		b.push_back(c[7:0]);
		// cut one to four fcs bytes off, so the frame may run past the end of the buffer
		if (flaw == FLAW_TRUNC)
			repeat ($urandom_range(1, 4)) void'(b.pop_back());
	endfunction

	function automatic int push_buffer(ref logic [7:0] b[$]);
		int i;
		byte_word_t w;
		for (i = 0; i < b.size(); i++) begin
			w.data = b[i];
			w.last = (i == b.size() - 1);
			word_q.push_back(w);
		end
		return b.size();
	endfunction

	function automatic int queue_random_buffer();
		logic [7:0] b[$];
		int frames;
		int dlen;
		logic [7:0] cmd;
		flaw_t flaw;
		append_noise(b, ($urandom_range(3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6),
			15);
		if ($urandom_range(9) != 0) begin
			frames = $urandom_range(1, 2);
			repeat (frames) begin
				cmd = ($urandom_range(9) < 7) ? want_cmd : 8'($urandom);
				dlen = ($urandom_range(15) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
				flaw = ($urandom_range(2) == 0) ? flaw_t'($urandom_range(1, 4)) : FLAW_NONE;
				append_frame(b, cmd, dlen, flaw);
				append_noise(b, $urandom_range(0, 2), 20);
			end
		end
		append_noise(b, $urandom_range(0, 4), 10);
		if (b.size() == 0)
			b.push_back(8'($urandom));
		return push_buffer(b);
	endfunction

	// sender: offers queued words, feeds the predictor on every accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in.valid <= 1'b0;
			byte_in.data_byte <= 8'h00;
			byte_in.is_last <= 1'b0;
		end else begin
			if (byte_in.valid && byte_in.ready)
				take_byte(byte_in.data_byte, byte_in.is_last);
			if (!byte_in.valid || byte_in.ready) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_in.valid <= 1'b1;
					byte_in.data_byte <= word_q[0].data;
					byte_in.is_last <= word_q[0].last;
					void'(word_q.pop_front());
				end else begin
					byte_in.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, armed once by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_arm)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endfunction

	// receiver: checks each accepted result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_out.ready <= 1'b0;
		end else begin
			if (verdict_out.valid && verdict_out.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual found=%0d offset=%0d ovf=%0d",
						$time, verdict_out.frame_found, verdict_out.frame_offset,
						verdict_out.overflowed);
					errors++;
				end else begin
					due_r = verdict_q.pop_front();
					check_field("frame_found", due_r.frame_found, verdict_out.frame_found);
					check_field("frame_offset", due_r.frame_offset, verdict_out.frame_offset);
					check_field("overflowed", due_r.overflowed, verdict_out.overflowed);
				end
			end
			verdict_out.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (word_q.size() != 0 || byte_in.valid || verdict_q.size() != 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_config(logic [7:0] cmd, logic any);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cfff_pkg::REG_WANTED_COMMAND;
		cfg_data <= cmd;
		@(posedge clk);
		cfg_index <= cfff_pkg::REG_MATCH_ANY;
		cfg_data <= {7'b0, any};
		@(posedge clk);
		cfg_we <= 1'b0;
		want_cmd = cmd;
		any_cmd = any;
	endtask

	initial begin
		logic [7:0] b[$];
		int sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cfff_pkg::REG_WANTED_COMMAND;
		cfg_data = 8'h00;
		hold_arm = 1'b0;
		send_idle_pct = 36;
		recv_idle_pct = 80;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed, reset configuration: one-byte buffer, minimal frame,
		// frame behind a 0xff byte, and a frame one byte short
		b = {8'h00};
		void'(push_buffer(b));
		b = {};
		append_frame(b, 8'h00, 0, FLAW_NONE);
		void'(push_buffer(b));
		b = {8'hFF};
		append_frame(b, 8'hFF, 0, FLAW_NONE);
		void'(push_buffer(b));
		b = {};
		append_frame(b, 8'h5A, 0, FLAW_NONE);
		void'(b.pop_back());
		void'(push_buffer(b));
		wait_idle();

		set_config(8'h00, 1'b0);
		sent = 0;
		while (sent < 540)
			sent += queue_random_buffer();
		wait_idle();

		send_idle_pct = 80;
		recv_idle_pct = 36;
		set_config(8'hFF, 1'b0);
		sent = 0;
		while (sent < 540)
			sent += queue_random_buffer();
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(8'($urandom), 1'b1);
		sent = 0;
		while (sent < 540)
			sent += queue_random_buffer();
		// receiver stalls while the sender keeps pushing, so the block backs up
		@(posedge clk) hold_arm <= 1'b1;
		@(posedge clk) hold_arm <= 1'b0;
		wait_idle();

		// long buffer with the frame at a far offset
		set_config(8'($urandom), 1'b0);
		b = {};
		append_noise(b, $urandom_range(180, 240), 2);
		append_frame(b, want_cmd, $urandom_range(0, 40), FLAW_NONE);
		append_noise(b, $urandom_range(0, 3), 0);
		void'(push_buffer(b));
		wait_idle();

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
